### hw/rtl/hpt_pkg.sv
// Shared constants, types and helpers for the homogeneous point transform.
package hpt_pkg;

    // Default number of fraction bits of all fixed-point values
    localparam int FRAC_BITS_DEF = 16;

    // Configuration register map (one 64-bit register every 8 bytes)
    localparam int NUM_REGS = 8;
    localparam int ADDR_W   = 6;
    localparam int IDX_LSB  = 3;

    localparam logic [2:0] REG_ROW0_LO = 3'd0;
    localparam logic [2:0] REG_ROW0_HI = 3'd1;
    localparam logic [2:0] REG_ROW1_LO = 3'd2;
    localparam logic [2:0] REG_ROW1_HI = 3'd3;
    localparam logic [2:0] REG_ROW2_LO = 3'd4;
    localparam logic [2:0] REG_ROW2_HI = 3'd5;
    localparam logic [2:0] REG_ROW3_LO = 3'd6;
    localparam logic [2:0] REG_ROW3_HI = 3'd7;

    // Quotient bits produced by the divider chain
    localparam int QUOT_W = 32;

    // Whole matrix as held by the register file
    typedef logic [NUM_REGS-1:0][63:0] hpt_mat_t;

    // Control that travels alongside each item through the divider chain
    typedef struct packed {
        logic       valid;
        logic       zero_w;
        logic       skip;
        logic [2:0] neg;
    } hpt_ctl_t;

    // Matrix entry M[r][c]: register (r*2 + c/2), half c%2
    function automatic logic signed [31:0] mat_entry(hpt_mat_t m, logic [1:0] r,
                                                     logic [1:0] c);
        logic [63:0] w;
        w = m[{r, c[1]}];
        return c[0] ? $signed(w[63:32]) : $signed(w[31:0]);
    endfunction

endpackage

### hw/rtl/hpt_ifs.sv
// Valid/ready channel interfaces for points in and transformed points out.
interface hpt_point_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;

    modport source (output valid, output point_x, output point_y, output point_z,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z,
                    output ready);
endinterface

interface hpt_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               zero_weight;

    modport source (output valid, output out_x, output out_y, output out_z,
                    output zero_weight, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z,
                     input zero_weight, output ready);
endinterface

### hw/rtl/hpt_cfg_regs.sv
// APB register file holding the 4x4 transform matrix.
module hpt_cfg_regs
    import hpt_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready,
    output hpt_mat_t          mat
);

    localparam logic [63:0] ONE_FX = 64'(1) << FRAC_BITS;

    hpt_mat_t   mat_reg;
    logic [2:0] idx;
    logic       wr_en;

    assign idx    = paddr[ADDR_W-1:IDX_LSB];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = mat_reg[idx];
    assign mat    = mat_reg;

    // Matrix registers, identity after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg[REG_ROW0_LO] <= ONE_FX;
            mat_reg[REG_ROW0_HI] <= '0;
            mat_reg[REG_ROW1_LO] <= ONE_FX << 32;
            mat_reg[REG_ROW1_HI] <= '0;
            mat_reg[REG_ROW2_LO] <= '0;
            mat_reg[REG_ROW2_HI] <= ONE_FX;
            mat_reg[REG_ROW3_LO] <= '0;
            mat_reg[REG_ROW3_HI] <= ONE_FX << 32;
        end
        else if (wr_en)
        begin
            mat_reg[idx] <= pwdata;
        end
    end

endmodule

### hw/rtl/hpt_dot.sv
// Two-stage dot product of the row vector (x, y, z, 1) with each matrix column.
module hpt_dot
    import hpt_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int VW = 66 - FRAC_BITS
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic signed [31:0]          px,
    input  logic signed [31:0]          py,
    input  logic signed [31:0]          pz,
    input  hpt_mat_t                    mat,
    output logic                        out_valid,
    output logic [3:0][VW-1:0]          col_sum
);

    localparam int SW = 66;

    logic                     prod_valid_reg;
    logic [3:0][2:0][63:0]    prod_reg;
    logic [3:0][2:0][63:0]    prod_next;
    logic                     sum_valid_reg;
    logic [3:0][VW-1:0]       sum_reg;
    logic [3:0][VW-1:0]       sum_next;
    logic signed [SW-1:0]     acc;
    logic signed [SW-1:0]     acc_sh;
    logic signed [31:0]       trans;

    // Stage A: twelve 32x32 products
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            prod_next[c][0] = 64'(px * mat_entry(mat, 2'd0, 2'(c)));
            prod_next[c][1] = 64'(py * mat_entry(mat, 2'd1, 2'(c)));
            prod_next[c][2] = 64'(pz * mat_entry(mat, 2'd2, 2'(c)));
        end
    end

    // Stage B: exact sum, floor to fraction bits, add row-3 entry
    always_comb
    begin
        acc    = '0;
        acc_sh = '0;
        trans  = '0;
        for (int c = 0; c < 4; c++)
        begin
            acc = SW'($signed(prod_reg[c][0])) + SW'($signed(prod_reg[c][1]))
                + SW'($signed(prod_reg[c][2]));
            acc_sh = acc >>> FRAC_BITS;
            trans  = mat_entry(mat, 2'd3, 2'(c));
            sum_next[c] = acc_sh[VW-1:0] + VW'(trans);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            prod_valid_reg <= in_valid;
            sum_valid_reg  <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            sum_reg  <= sum_next;
        end
    end

    assign out_valid = sum_valid_reg;
    assign col_sum   = sum_reg;

endmodule

### hw/rtl/hpt_div_cell.sv
// One restoring-division cell: decides one quotient bit for all three lanes.
module hpt_div_cell
    import hpt_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int SHIFT     = 0,
    localparam int VW = 66 - FRAC_BITS,
    localparam int RW = 98 - FRAC_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  hpt_ctl_t                 ctl_in,
    input  logic [2:0][RW-1:0]       rem_in,
    input  logic [2:0][QUOT_W-1:0]   q_in,
    input  logic [VW-1:0]            d_in,
    input  logic [2:0][31:0]         pass_in,
    output hpt_ctl_t                 ctl_out,
    output logic [2:0][RW-1:0]       rem_out,
    output logic [2:0][QUOT_W-1:0]   q_out,
    output logic [VW-1:0]            d_out,
    output logic [2:0][31:0]         pass_out
);

    hpt_ctl_t                 ctl_reg;
    logic [2:0][RW-1:0]       rem_reg;
    logic [2:0][RW-1:0]       rem_next;
    logic [2:0][QUOT_W-1:0]   q_reg;
    logic [2:0][QUOT_W-1:0]   q_next;
    logic [VW-1:0]            d_reg;
    logic [2:0][31:0]         pass_reg;
    logic [RW-1:0]            d_sh;
    logic                     ge;

    // Compare and subtract the shifted divisor
    always_comb
    begin
        d_sh = RW'(d_in) << SHIFT;
        ge   = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            ge          = rem_in[i] >= d_sh;
            rem_next[i] = ge ? rem_in[i] - d_sh : rem_in[i];
            q_next[i]   = q_in[i];
            q_next[i][SHIFT] = ge;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            q_reg    <= q_next;
            d_reg    <= d_in;
            pass_reg <= pass_in;
        end
    end

    assign ctl_out  = ctl_reg;
    assign rem_out  = rem_reg;
    assign q_out    = q_reg;
    assign d_out    = d_reg;
    assign pass_out = pass_reg;

endmodule

### hw/rtl/homogeneous_point_transform_top.sv
// Top level: matrix registers, dot products, divider cell chain and output register.
//
//  channel | dir | handshake     | payload
//  point   | in  | valid/ready   | point_x, point_y, point_z (s32 Q.F)
//  result  | out | valid/ready   | out_x, out_y, out_z (s32), zero_weight
//  apb     | in  | psel/penable  | paddr[5:0], pwdata/prdata 64 bits
//
//  One item per cycle sustained while results are taken; the pipeline has
//  2 dot-product stages, 1 divide setup stage, 32 divider cells, 1 output register.
//  The whole pipeline advances together; it holds while the output item waits.
//  Reset clears all valid bits and loads the identity matrix.
module homogeneous_point_transform_top
    import hpt_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready,
    hpt_point_if.sink         point,
    hpt_result_if.source      result
);

    localparam int VW = 66 - FRAC_BITS;
    localparam int RW = 98 - FRAC_BITS;
    localparam logic [VW-1:0] ONE_FX = VW'(1) << FRAC_BITS;

    function automatic logic [31:0] sat32(logic signed [VW-1:0] v);
        if (v > VW'(32'sh7FFF_FFFF))
            return 32'h7FFF_FFFF;
        else if (v < VW'(-33'sh8000_0000))
            return 32'h8000_0000;
        else
            return v[31:0];
    endfunction

    hpt_mat_t               mat;
    logic                   adv;
    logic                   dot_valid;
    logic [3:0][VW-1:0]     col_sum;

    // Chain stage signals, index 0 feeds the first cell
    hpt_ctl_t               ctl_s  [0:QUOT_W];
    logic [2:0][RW-1:0]     rem_s  [0:QUOT_W];
    logic [2:0][QUOT_W-1:0] q_s    [0:QUOT_W];
    logic [VW-1:0]          d_s    [0:QUOT_W];
    logic [2:0][31:0]       pass_s [0:QUOT_W];

    hpt_ctl_t               setup_ctl_reg;
    hpt_ctl_t               setup_ctl_next;
    logic [2:0][RW-1:0]     setup_rem_reg;
    logic [2:0][RW-1:0]     setup_rem_next;
    logic [VW-1:0]          setup_d_reg;
    logic [VW-1:0]          setup_d_next;
    logic [2:0][31:0]       setup_pass_reg;
    logic [2:0][31:0]       setup_pass_next;
    logic signed [VW-1:0]   wv;
    logic signed [VW-1:0]   cv;
    logic [VW-1:0]          mag;

    logic                   res_valid_reg;
    logic [2:0][31:0]       res_reg;
    logic [2:0][31:0]       res_next;
    logic                   res_zero_reg;
    logic [31:0]            qv;

    // Whole pipeline moves when the output register is free or being taken
    assign adv         = !res_valid_reg || result.ready;
    assign point.ready = adv;

    hpt_cfg_regs #(.FRAC_BITS(FRAC_BITS)) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .mat     (mat)
    );

    hpt_dot #(.FRAC_BITS(FRAC_BITS)) u_dot (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (point.valid),
        .px        (point.point_x),
        .py        (point.point_y),
        .pz        (point.point_z),
        .mat       (mat),
        .out_valid (dot_valid),
        .col_sum   (col_sum)
    );

    // Divide setup: magnitudes, signs, weight checks, saturated pass values
    always_comb
    begin
        wv  = $signed(col_sum[3]);
        cv  = '0;
        mag = '0;
        setup_ctl_next.valid  = dot_valid;
        setup_ctl_next.zero_w = (col_sum[3] == '0);
        setup_ctl_next.skip   = (col_sum[3] == '0) || (col_sum[3] == ONE_FX);
        setup_ctl_next.neg    = '0;
        setup_d_next = wv[VW-1] ? VW'(-wv) : col_sum[3];
        for (int i = 0; i < 3; i++)
        begin
            cv  = $signed(col_sum[i]);
            mag = cv[VW-1] ? VW'(-cv) : col_sum[i];
            setup_ctl_next.neg[i] = cv[VW-1] ^ wv[VW-1];
            setup_rem_next[i]     = RW'(mag) << FRAC_BITS;
            setup_pass_next[i]    = sat32(cv);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setup_ctl_reg <= '0;
        end
        else if (adv)
        begin
            setup_ctl_reg <= setup_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            setup_rem_reg  <= setup_rem_next;
            setup_d_reg    <= setup_d_next;
            setup_pass_reg <= setup_pass_next;
        end
    end

    assign ctl_s[0]  = setup_ctl_reg;
    assign rem_s[0]  = setup_rem_reg;
    assign q_s[0]    = '0;
    assign d_s[0]    = setup_d_reg;
    assign pass_s[0] = setup_pass_reg;

    // Divider chain, one quotient bit per cell, most significant first
    for (genvar j = 0; j < QUOT_W; j++)
    begin : g_cell
        hpt_div_cell #(.FRAC_BITS(FRAC_BITS), .SHIFT(QUOT_W - 1 - j)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .ctl_in   (ctl_s[j]),
            .rem_in   (rem_s[j]),
            .q_in     (q_s[j]),
            .d_in     (d_s[j]),
            .pass_in  (pass_s[j]),
            .ctl_out  (ctl_s[j+1]),
            .rem_out  (rem_s[j+1]),
            .q_out    (q_s[j+1]),
            .d_out    (d_s[j+1]),
            .pass_out (pass_s[j+1])
        );
    end

    // Sign and saturate quotient, or pass the undivided point
    always_comb
    begin
        qv = '0;
        for (int i = 0; i < 3; i++)
        begin
            qv = q_s[QUOT_W][i];
            if (ctl_s[QUOT_W].skip)
                res_next[i] = pass_s[QUOT_W][i];
            else if (qv[QUOT_W-1])
                res_next[i] = ctl_s[QUOT_W].neg[i] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            else
                res_next[i] = ctl_s[QUOT_W].neg[i] ? 32'(-qv) : qv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            res_valid_reg <= ctl_s[QUOT_W].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg      <= res_next;
            res_zero_reg <= ctl_s[QUOT_W].zero_w;
        end
    end

    assign result.valid       = res_valid_reg;
    assign result.out_x       = $signed(res_reg[0]);
    assign result.out_y       = $signed(res_reg[1]);
    assign result.out_z       = $signed(res_reg[2]);
    assign result.zero_weight = res_zero_reg;

endmodule

### verif/homogeneous_point_transform_top_tb.sv
// Testbench for the homogeneous point transform: APB setup, random points, scoreboard.
`timescale 1ns / 1ps

// Expected transformed points, in order of acceptance
class hpt_point_scoreboard;
    logic [63:0] mat [8];
    logic [31:0] exp_x [$];
    logic [31:0] exp_y [$];
    logic [31:0] exp_z [$];
    logic        exp_zw [$];
    int          errors;

    function new();
        errors = 0;
        mat[0] = 64'h1_0000;
        mat[1] = 64'd0;
        mat[2] = 64'h1_0000 << 32;
        mat[3] = 64'd0;
        mat[4] = 64'd0;
        mat[5] = 64'h1_0000;
        mat[6] = 64'd0;
        mat[7] = 64'h1_0000 << 32;
    endfunction

    function logic signed [63:0] coef(int r, int c);
        logic [63:0] w;
        w = mat[r * 2 + c / 2];
        return (c % 2) ? {{32{w[63]}}, w[63:32]} : {{32{w[31]}}, w[31:0]};
    endfunction

    // Column dot product: exact sum of products floored to 16 fraction bits, plus the row-3 entry
    function logic signed [63:0] column_sum(logic signed [63:0] p [3], int c);
        logic signed [95:0] acc;
        logic signed [95:0] prod;
        acc = '0;
        for (int i = 0; i < 3; i++)
        begin
            prod = 96'(p[i]) * 96'(coef(i, c));
            acc = acc + prod;
        end
        acc = (acc >>> 16) + 96'(coef(3, c));
        return acc[63:0];
    endfunction

    function logic [31:0] clamp(logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF)
            return 32'h7FFF_FFFF;
        if (v < -64'sh8000_0000)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    // Quotient truncated toward zero, then saturated
    function logic [31:0] divide(logic signed [63:0] num, logic signed [63:0] den);
        logic        neg;
        logic [63:0] n;
        logic [63:0] d;
        logic [95:0] q;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        q = ({32'd0, n} << 16) / {32'd0, d};
        if (neg)
            return (q >= 96'h8000_0000) ? 32'h8000_0000 : 32'(-q);
        return (q > 96'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    endfunction

    function void note_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        logic signed [63:0] p [3];
        logic signed [63:0] v [3];
        logic signed [63:0] w;
        logic [31:0] r [3];
        p[0] = $signed(x);
        p[1] = $signed(y);
        p[2] = $signed(z);
        for (int c = 0; c < 3; c++)
            v[c] = column_sum(p, c);
        w = column_sum(p, 3);
        for (int c = 0; c < 3; c++)
            r[c] = (w == 0 || w == 64'sh1_0000) ? clamp(v[c]) : divide(v[c], w);
        exp_x.push_back(r[0]);
        exp_y.push_back(r[1]);
        exp_z.push_back(r[2]);
        exp_zw.push_back(w == 0);
    endfunction

    function void check_result(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                               logic zw);
        logic [31:0] ex;
        logic [31:0] ey;
        logic [31:0] ez;
        logic        ezw;
        if (exp_x.size() == 0)
        begin
            $error("unexpected result item x=%h", x);
            errors++;
            return;
        end
        ex = exp_x.pop_front();
        ey = exp_y.pop_front();
        ez = exp_z.pop_front();
        ezw = exp_zw.pop_front();
        if (x !== ex)
        begin
            $error("out_x expected %h actual %h", ex, x);
            errors++;
        end
        if (y !== ey)
        begin
            $error("out_y expected %h actual %h", ey, y);
            errors++;
        end
        if (z !== ez)
        begin
            $error("out_z expected %h actual %h", ez, z);
            errors++;
        end
        if (zw !== ezw)
        begin
            $error("zero_weight expected %b actual %b", ezw, zw);
            errors++;
        end
    endfunction

    function int pending();
        return exp_x.size();
    endfunction
endclass

module homogeneous_point_transform_top_tb;
    import hpt_pkg::*;

    localparam int LATENCY = 36;
    localparam longint CYCLE_LIMIT = 400000;
    localparam logic [63:0] ONE = 64'h1_0000;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [63:0]       pwdata;
    logic [63:0]       prdata;
    logic              pready;
    logic              src_idle;
    logic              sink_idle;
    longint            cycles;

    hpt_point_if  point ();
    hpt_result_if result ();

    hpt_point_scoreboard sb;

    homogeneous_point_transform_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .point   (point.sink),
        .result  (result.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run timeout
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("homogeneous_point_transform_top regression: fail");
                $finish;
            end
        end
    end

    // Result sink: random stall bursts, checks every accepted item
    initial
    begin
        int burst;
        result.ready = 1'b0;
        burst = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (result.valid && result.ready)
                sb.check_result(result.out_x, result.out_y, result.out_z,
                                result.zero_weight);
            if (burst > 0)
                burst--;
            else if (!sink_idle && $urandom_range(0, 5) == 0)
                burst = $urandom_range(1, 8);
            result.ready <= (burst == 0);
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << IDX_LSB;
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        sb.mat[idx] = val;
    endtask

    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        if (!src_idle && $urandom_range(0, 5) == 0)
        begin
            point.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        point.valid   <= 1'b1;
        point.point_x <= x;
        point.point_y <= y;
        point.point_z <= z;
        @(posedge clk);
        while (!point.ready)
            @(posedge clk);
        sb.note_point(x, y, z);
    endtask

    // Wait for all results, then past the pipeline depth
    task automatic drain();
        point.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 1) ? 32'($urandom_range(0, 8) << 16)
                                           : -32'($urandom_range(0, 8) << 16);
            3: return 32'($signed($urandom_range(0, 32'h7_FFFF)) - 32'sh4_0000);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] rand_entry();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'd0;
            3: return 32'($signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000);
            default: return $urandom();
        endcase
    endfunction

    task automatic random_matrix(int style);
        logic [31:0] e [4][4];
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                e[r][c] = rand_entry();
        // affine matrices keep weight at exactly one
        if (style == 0)
        begin
            e[0][3] = 0;
            e[1][3] = 0;
            e[2][3] = 0;
            e[3][3] = ONE[31:0];
        end
        // weight taken from z alone, may land on zero
        else if (style == 1)
        begin
            e[0][3] = 0;
            e[1][3] = 0;
            e[2][3] = ONE[31:0];
            e[3][3] = 0;
        end
        for (int r = 0; r < 4; r++)
        begin
            reg_write(3'(r * 2), {e[r][1], e[r][0]});
            reg_write(3'(r * 2 + 1), {e[r][3], e[r][2]});
        end
    endtask

    initial
    begin
        logic [31:0] corners [4];
        sb = new();
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        point.valid = 1'b0;
        point.point_x = '0;
        point.point_y = '0;
        point.point_z = '0;
        src_idle = 1'b0;
        sink_idle = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: identity at reset, field extremes
        corners[0] = 32'h8000_0000;
        corners[1] = 32'h7FFF_FFFF;
        corners[2] = 32'h0;
        corners[3] = 32'hFFFF_FFFF;
        for (int i = 0; i < 4; i++)
            send_point(corners[i], corners[(i + 1) % 4], corners[(i + 2) % 4]);
        drain();

        // Perspective: w = z, zero weight on z = 0, divide otherwise
        reg_write(REG_ROW2_HI, {ONE[31:0], ONE[31:0]});
        reg_write(REG_ROW3_HI, 64'd0);
        reg_write(REG_ROW3_LO, {32'h0002_0000, 32'hFFFF_0000});
        send_point(32'h0003_0000, 32'h0004_0000, 32'h0);
        send_point(32'h0003_0000, 32'h0004_0000, 32'h0002_0000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_point(32'h0001_0000, 32'h0, 32'hFFFF_0000);
        send_point(32'h0, 32'h0, 32'h0);
        drain();

        // All-extreme matrices: every register bit set, then negative extremes, then positive extremes
        for (int i = 0; i < NUM_REGS; i++)
            reg_write(3'(i), 64'hFFFF_FFFF_FFFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        drain();
        for (int i = 0; i < NUM_REGS; i++)
            reg_write(3'(i), 64'h8000_0000_8000_0000);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        drain();
        for (int i = 0; i < NUM_REGS; i++)
            reg_write(3'(i), 64'h7FFF_FFFF_7FFF_FFFF);
        send_point(32'h7FFF_FFFF, 32'h0, 32'h8000_0000);
        send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        drain();

        // Random phases over random matrices
        for (int ph = 0; ph < 12; ph++)
        begin
            random_matrix(ph % 3);
            if (ph >= 10)
            begin
                src_idle = 1'b1;
                sink_idle = 1'b1;
            end
            for (int n = 0; n < 100; n++)
                send_point(rand_coord(), rand_coord(), rand_coord());
            drain();
        end

        if (sb.errors == 0)
            $display("homogeneous_point_transform_top regression: pass");
        else
            $display("homogeneous_point_transform_top regression: fail");
        $finish;
    end
endmodule

### files.f
hw/rtl/hpt_pkg.sv
hw/rtl/hpt_ifs.sv
hw/rtl/hpt_cfg_regs.sv
hw/rtl/hpt_dot.sv
hw/rtl/hpt_div_cell.sv
hw/rtl/homogeneous_point_transform_top.sv
verif/homogeneous_point_transform_top_tb.sv
